// ===== rtl/ctcgd_pkg.sv =====
package ctcgd_pkg;

  localparam int unsigned CLS_W   = 13;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned SUM_W   = 26;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [CLS_W-1:0] DICT_RESET = 13'd8191;
  localparam logic [CLS_W-1:0] BLANK      = '0;

  typedef struct packed {
    logic               nochar;
    logic               eol;
    logic [CLS_W-1:0]   cls;
    logic [SUM_W-1:0]   sum;
    logic [LEN_W-1:0]   len;
    logic [STEP_W-1:0]  first;
    logic [STEP_W-1:0]  final_s;
  } run_rec_t;

  typedef struct packed {
    logic     push0;
    logic     push1;
    run_rec_t rec0;
    run_rec_t rec1;
  } q_push_t;

endpackage

// ===== rtl/ctc_greedy_decoder_core.sv =====
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    score, last_class, last_step
// out       output     out_valid/out_ready  char_index .. end_of_line
// cfg       input      cfg_wr_en            cfg_wr_data (dictionary size)
//
// one score beat per cycle while the run queue has room for two records
// each emitted run passes through the back end's idle, bit-serial mean divider and hold states
// an empty marker skips the divider; the queue holds 4 records
// rst is synchronous: scores, runs and queue clear, dictionary size returns to 8191
// out stalls back up through the queue to in_ready only when the queue holds more than two records
module ctc_greedy_decoder_core
  import ctcgd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 8192,
  parameter int unsigned MAX_STEPS   = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CLS_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SCORE_W-1:0] score,
  input  logic               last_class,
  input  logic               last_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CLS_W-1:0]   char_index,
  output logic               outside_dictionary,
  output logic [SCORE_W-1:0] mean_confidence,
  output logic [STEP_W-1:0]  first_step,
  output logic [STEP_W-1:0]  final_step,
  output logic               no_character,
  output logic               end_of_line
);

  logic [CLS_W-1:0]  dictionary_size;
  q_push_t           q_wr;
  run_rec_t          q_data;
  logic              q_empty;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      dictionary_size <= DICT_RESET;
    end else if (cfg_wr_en) begin
      dictionary_size <= cfg_wr_data;
    end
  end

  assign in_ready = q_count <= QCNT_W'(QDEPTH - 2);

  ctcgd_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_STEPS   (MAX_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_valid && in_ready),
    .score      (score),
    .last_class (last_class),
    .last_step  (last_step),
    .wr         (q_wr)
  );

  ctcgd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty),
    .count   (q_count)
  );

  ctcgd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .dict_size          (dictionary_size),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .char_index         (char_index),
    .outside_dictionary (outside_dictionary),
    .mean_confidence    (mean_confidence),
    .first_step         (first_step),
    .final_step         (final_step),
    .no_character       (no_character),
    .end_of_line        (end_of_line)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("run queue overflow");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_character |-> end_of_line && char_index == '0 && mean_confidence == '0)
    else $error("empty marker carries data");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_character |-> first_step <= final_step)
    else $error("run ends before it begins");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/ctcgd_fifo.sv =====
module ctcgd_fifo
  import ctcgd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  q_push_t               wr,
  input  logic                  pop,
  output run_rec_t              rd_data,
  output logic                  empty,
  output logic [QCNT_W-1:0]     count
);

  run_rec_t             mem [QDEPTH];
  logic [QPTR_W-1:0]    wptr;
  logic [QPTR_W-1:0]    rptr;
  logic [QPTR_W-1:0]    wptr_inc;
  logic [QCNT_W-1:0]    n_push;

  assign wptr_inc = wptr + QPTR_W'(1);
  assign n_push   = QCNT_W'(wr.push0) + QCNT_W'(wr.push0 & wr.push1);
  assign rd_data  = mem[rptr];
  assign empty    = (count == '0);

  always_ff @(posedge clk) begin
    if (wr.push0) begin
      mem[wptr] <= wr.rec0;
    end
    if (wr.push0 && wr.push1) begin
      mem[wptr_inc] <= wr.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(n_push);
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + n_push - QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/ctcgd_front.sv =====
module ctcgd_front
  import ctcgd_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 8192,
  parameter int unsigned MAX_STEPS   = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [SCORE_W-1:0] score,
  input  logic               last_class,
  input  logic               last_step,
  output q_push_t            wr
);

  localparam int unsigned CC_W = $clog2(MAX_CLASSES + 1);

  logic [SCORE_W-1:0] step_max_score;
  logic [CLS_W-1:0]   step_max_class;
  logic [CC_W-1:0]    class_counter;
  logic [STEP_W-1:0]  step_counter;
  logic [CLS_W-1:0]   previous_best;
  logic               run_open;
  run_rec_t           run;

  logic               cc_ok;
  logic               take;
  logic [SCORE_W-1:0] cur_score;
  logic [CLS_W-1:0]   cur_class;
  logic               extend;
  logic               open_new;
  logic               emit_close;
  logic               run_open_next;
  run_rec_t           run_next;
  run_rec_t           rec_end;
  run_rec_t           rec_closed;

  assign cc_ok     = class_counter < CC_W'(MAX_CLASSES);
  assign take      = cc_ok && ((class_counter == '0) || (score > step_max_score));
  assign cur_score = take ? score : step_max_score;
  assign cur_class = take ? CLS_W'(class_counter) : step_max_class;

  assign extend     = (cur_class != BLANK) && (cur_class == previous_best) && run_open;
  assign open_new   = (cur_class != BLANK) && !extend;
  assign emit_close = open_new && run_open;

  always_comb begin
    run_next      = run;
    run_open_next = run_open;
    if (extend) begin
      run_next.final_s = step_counter;
      if (run.len < LEN_W'(MAX_STEPS)) begin
        run_next.sum = run.sum + SUM_W'(cur_score);
        run_next.len = run.len + LEN_W'(1);
      end
    end else if (open_new) begin
      run_open_next    = 1'b1;
      run_next.cls     = cur_class;
      run_next.sum     = SUM_W'(cur_score);
      run_next.len     = LEN_W'(1);
      run_next.first   = step_counter;
      run_next.final_s = step_counter;
    end
  end

  always_comb begin
    rec_closed        = run;
    rec_closed.nochar = 1'b0;
    rec_closed.eol    = 1'b0;
    if (run_open_next) begin
      rec_end        = run_next;
      rec_end.nochar = 1'b0;
      rec_end.eol    = 1'b1;
    end else begin
      rec_end        = '0;
      rec_end.nochar = 1'b1;
      rec_end.eol    = 1'b1;
    end
  end

  always_comb begin
    wr       = '0;
    wr.rec0  = emit_close ? rec_closed : rec_end;
    wr.rec1  = rec_end;
    wr.push0 = accept && last_class && (emit_close || last_step);
    wr.push1 = accept && last_class && emit_close && last_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_max_score <= '0;
      step_max_class <= '0;
      class_counter  <= '0;
      step_counter   <= '0;
      previous_best  <= BLANK;
      run_open       <= 1'b0;
      run            <= '0;
    end else if (accept) begin
      if (last_class) begin
        step_max_score <= '0;
        step_max_class <= '0;
        class_counter  <= '0;
        if (last_step) begin
          step_counter  <= '0;
          previous_best <= BLANK;
          run_open      <= 1'b0;
          run           <= '0;
        end else begin
          if (step_counter < STEP_W'(MAX_STEPS - 1)) begin
            step_counter <= step_counter + STEP_W'(1);
          end
          previous_best <= cur_class;
          run_open      <= run_open_next;
          run           <= run_next;
        end
      end else if (cc_ok) begin
        step_max_score <= cur_score;
        step_max_class <= cur_class;
        class_counter  <= class_counter + CC_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ctcgd_back.sv =====
module ctcgd_back
  import ctcgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [CLS_W-1:0]   dict_size,
  input  logic               q_empty,
  input  run_rec_t           q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CLS_W-1:0]   char_index,
  output logic               outside_dictionary,
  output logic [SCORE_W-1:0] mean_confidence,
  output logic [STEP_W-1:0]  first_step,
  output logic [STEP_W-1:0]  final_step,
  output logic               no_character,
  output logic               end_of_line
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t               state;
  run_rec_t             rec;
  logic [STEP_W-1:0]    rem;
  logic [SCORE_W-1:0]   dvd;
  logic [SCORE_W-1:0]   quo;
  logic [3:0]           bit_cnt;
  logic [LEN_W-1:0]     trial;
  logic                 fits;
  logic                 out_free;
  logic [CLS_W-1:0]     idx;

  assign trial    = {rem, dvd[SCORE_W-1]};
  assign fits     = trial >= rec.len;
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign idx      = rec.cls - CLS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= q_data.nochar ? S_HOLD : S_DIV;
          end
        end
        S_DIV: begin
          if (bit_cnt == 4'd15) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rec     <= q_data;
        rem     <= q_data.sum[SUM_W-1:SCORE_W];
        dvd     <= q_data.sum[SCORE_W-1:0];
        quo     <= '0;
        bit_cnt <= '0;
      end
      S_DIV: begin
        rem     <= fits ? STEP_W'(trial - rec.len) : trial[STEP_W-1:0];
        dvd     <= {dvd[SCORE_W-2:0], 1'b0};
        quo     <= {quo[SCORE_W-2:0], fits};
        bit_cnt <= bit_cnt + 4'd1;
      end
      S_HOLD: begin
        if (out_free) begin
          if (rec.nochar) begin
            char_index         <= '0;
            outside_dictionary <= 1'b0;
            mean_confidence    <= '0;
          end else begin
            char_index         <= idx;
            outside_dictionary <= idx >= dict_size;
            mean_confidence    <= quo;
          end
          first_step   <= rec.first;
          final_step   <= rec.final_s;
          no_character <= rec.nochar;
          end_of_line  <= rec.eol;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import ctcgd_pkg::*;

  localparam int MAX_CLS     = 8192;
  localparam int MAX_STP     = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYC  = 60;
  localparam int HOLD_CYC    = 500;

  typedef struct packed {
    logic [CLS_W-1:0]   char_index;
    logic               outside;
    logic [SCORE_W-1:0] mean;
    logic [STEP_W-1:0]  start_step;
    logic [STEP_W-1:0]  stop_step;
    logic               nochar;
    logic               eol;
  } char_rec_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    bit                 lc;
    bit                 ls;
    bit                 typed;
    char_rec_t          want;
  } stim_row_t;

  localparam char_rec_t EMPTY_MARK = '{char_index: '0, outside: 1'b0, mean: '0,
                                       start_step: '0, stop_step: '0, nochar: 1'b1, eol: 1'b1};
  localparam char_rec_t FULL_SCORE = '{char_index: '0, outside: 1'b0, mean: 16'hffff,
                                       start_step: '0, stop_step: '0, nochar: 1'b0, eol: 1'b1};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CLS_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SCORE_W-1:0] score = '0;
  logic               last_class = 1'b0;
  logic               last_step = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CLS_W-1:0]   char_index;
  logic               outside_dictionary;
  logic [SCORE_W-1:0] mean_confidence;
  logic [STEP_W-1:0]  first_step;
  logic [STEP_W-1:0]  final_step;
  logic               no_character;
  logic               end_of_line;

  // beat attributes that travel with the payload
  bit        beat_typed = 1'b0;
  char_rec_t beat_want = '0;

  // decoder state kept by the testbench
  logic [CLS_W-1:0]   dict_size;
  logic [SCORE_W-1:0] top_score;
  logic [CLS_W-1:0]   top_class;
  logic [CLS_W:0]     cls_count;
  logic [STEP_W-1:0]  step_no;
  logic [CLS_W-1:0]   prev_winner;
  bit                 run_live;
  logic [CLS_W-1:0]   run_cls;
  logic [SUM_W-1:0]   run_sum;
  logic [LEN_W-1:0]   run_len;
  logic [STEP_W-1:0]  run_start;
  logic [STEP_W-1:0]  run_end;

  char_rec_t expected_chars[$];

  int  errors = 0;
  int  cycle_count = 0;
  int  beats_sent = 0;
  int  chars_checked = 0;
  int  sequences_done = 0;
  int  stall_cycles = 0;
  bit  calm = 1'b0;
  bit  hold_request = 1'b0;
  int  ready_gap = 0;

  stim_row_t directed_rows [18] = '{
    '{16'h0000, 1'b1, 1'b1, 1'b1, EMPTY_MARK},
    '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'hffff, 1'b1, 1'b1, 1'b1, FULL_SCORE},
    '{16'h1234, 1'b0, 1'b1, 1'b0, '0},
    '{16'h1234, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0001, 1'b1, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b1, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'h4000, 1'b1, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0001, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0002, 1'b1, 1'b1, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'hffff, 1'b0, 1'b0, 1'b0, '0},
    '{16'hffff, 1'b1, 1'b1, 1'b0, '0}
  };

  ctc_greedy_decoder_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .score              (score),
    .last_class         (last_class),
    .last_step          (last_step),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .char_index         (char_index),
    .outside_dictionary (outside_dictionary),
    .mean_confidence    (mean_confidence),
    .first_step         (first_step),
    .final_step         (final_step),
    .no_character       (no_character),
    .end_of_line        (end_of_line)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic char_rec_t run_record(bit eol);
    char_rec_t r;
    logic [CLS_W-1:0] idx;
    idx = run_cls - 1'b1;
    r = '0;
    r.char_index = idx;
    r.outside    = (idx >= dict_size);
    r.mean       = (run_len != 0) ? SCORE_W'(run_sum / run_len) : '0;
    r.start_step = run_start;
    r.stop_step  = run_end;
    r.eol        = eol;
    return r;
  endfunction

  task automatic queue_char(char_rec_t r);
    expected_chars.insert(expected_chars.size(), r);
  endtask

  task automatic clear_sequence();
    step_no     = '0;
    prev_winner = BLANK;
    run_live    = 1'b0;
    run_cls     = '0;
    run_sum     = '0;
    run_len     = '0;
    run_start   = '0;
    run_end     = '0;
  endtask

  task automatic clear_step_max();
    top_score = '0;
    top_class = '0;
    cls_count = '0;
  endtask

  task automatic decode_score(logic [SCORE_W-1:0] s, bit lc, bit ls);
    logic [CLS_W-1:0] best;
    if (cls_count < MAX_CLS) begin
      if (cls_count == 0 || s > top_score) begin
        top_score = s;
        top_class = cls_count[CLS_W-1:0];
      end
      cls_count++;
    end
    if (!lc) return;
    best = top_class;
    if (best != BLANK && best == prev_winner && run_live) begin
      run_end = step_no;
      if (run_len < MAX_STP) begin
        run_sum += top_score;
        run_len++;
      end
    end else if (best != BLANK) begin
      if (run_live) queue_char(run_record(1'b0));
      run_live  = 1'b1;
      run_cls   = best;
      run_sum   = SUM_W'(top_score);
      run_len   = LEN_W'(1);
      run_start = step_no;
      run_end   = step_no;
    end
    prev_winner = best;
    clear_step_max();
    if (step_no < MAX_STP - 1) step_no++;
    if (ls) begin
      if (run_live) queue_char(run_record(1'b1));
      else queue_char(EMPTY_MARK);
      clear_sequence();
      sequences_done++;
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    $display("mismatch %0d at cycle %0d: %s got %0d expected %0d",
             errors, cycle_count, field, got, want);
  endtask

  // prediction on accepted score beats, checking on accepted result beats
  always @(posedge clk) begin
    char_rec_t w;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
    if (rst) begin
      dict_size = DICT_RESET;
      clear_step_max();
      clear_sequence();
    end else begin
      if (cfg_wr_en) dict_size = cfg_wr_data;
      if (in_valid && !in_ready) stall_cycles++;
      if (in_valid && in_ready) begin
        decode_score(score, last_class, last_step);
        if (beat_typed) expected_chars[expected_chars.size()-1] = beat_want;
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected beat, char_index", char_index, -1);
        end else begin
          w = expected_chars.pop_front();
          if (char_index !== w.char_index)
            report_mismatch("char_index", char_index, w.char_index);
          if (outside_dictionary !== w.outside)
            report_mismatch("outside_dictionary", outside_dictionary, w.outside);
          if (mean_confidence !== w.mean)
            report_mismatch("mean_confidence", mean_confidence, w.mean);
          if (first_step !== w.start_step)
            report_mismatch("first_step", first_step, w.start_step);
          if (final_step !== w.stop_step)
            report_mismatch("final_step", final_step, w.stop_step);
          if (no_character !== w.nochar)
            report_mismatch("no_character", no_character, w.nochar);
          if (end_of_line !== w.eol)
            report_mismatch("end_of_line", end_of_line, w.eol);
        end
      end
    end
  end

  // result side: random back-pressure and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk);
      end else if (ready_gap > 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) ready_gap = idle_len();
      end
    end
  end

  task automatic send_beat(logic [SCORE_W-1:0] s, bit lc, bit ls,
                           bit typed = 1'b0, char_rec_t want = '0);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    score      <= s;
    last_class <= lc;
    last_step  <= ls;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_dictionary(logic [CLS_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_sequence();
    int n_steps;
    int n_cls;
    int winner;
    int prev_win;
    bit noisy;
    bit ls;
    logic [SCORE_W-1:0] top;
    logic [SCORE_W-1:0] s;
    n_steps  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    prev_win = 0;
    for (int t = 0; t < n_steps; t++) begin
      n_cls = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
      noisy = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2:    winner = 0;
        3, 4, 5, 6: winner = (prev_win < n_cls) ? prev_win : $urandom_range(0, n_cls - 1);
        default:    winner = $urandom_range(0, n_cls - 1);
      endcase
      prev_win = winner;
      top = SCORE_W'($urandom);
      for (int c = 0; c < n_cls; c++) begin
        if (noisy) s = SCORE_W'($urandom);
        else if (c == winner || $urandom_range(0, 7) == 0) s = top;
        else s = SCORE_W'($urandom_range(0, top));
        if (c == n_cls - 1) ls = (t == n_steps - 1);
        else ls = ($urandom_range(0, 9) == 0);
        send_beat(s, c == n_cls - 1, ls);
      end
    end
  endtask

  task automatic send_random(int n_beats);
    int start;
    start = beats_sent;
    while (beats_sent - start < n_beats) send_sequence();
  endtask

  initial begin
    int c1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].score, directed_rows[i].lc, directed_rows[i].ls,
                directed_rows[i].typed, directed_rows[i].want);
    settle();

    set_dictionary('0);
    send_random(260);
    settle();

    set_dictionary(13'd1);
    calm = 1'b1;
    send_random(260);
    calm = 1'b0;
    settle();

    set_dictionary(13'd3);
    hold_request = 1'b1;
    send_random(260);
    settle();

    set_dictionary(CLS_W'($urandom_range(2, 12)));
    send_random(260);
    settle();

    set_dictionary(CLS_W'($urandom));
    send_random(130);
    settle();

    set_dictionary(13'd8191);
    calm = 1'b1;
    // one step wider than the class limit, the extra scores must be ignored
    for (int c = 0; c < MAX_CLS + 8; c++) begin
      if (c < MAX_CLS - 1) send_beat(SCORE_W'($urandom_range(0, 16'hfffd)), 1'b0, 1'b0);
      else if (c == MAX_CLS - 1) send_beat(16'hfffe, 1'b0, 1'b0);
      else send_beat(16'hffff, c == MAX_CLS + 7, c == MAX_CLS + 7);
    end
    // one run longer than the step limit
    for (int t = 0; t < MAX_STP + 80; t++) begin
      c1 = $urandom_range(16'h8000, 16'hffff);
      send_beat(SCORE_W'($urandom_range(0, c1 - 1)), 1'b0, 1'b0);
      send_beat(SCORE_W'(c1), 1'b1, t == MAX_STP + 79);
    end
    calm = 1'b0;
    send_random(130);
    settle();

    $display("%0d score beats in %0d sequences, %0d result beats checked",
             beats_sent, sequences_done, chars_checked);
    $display("input held back for %0d cycles, dictionary sizes from 0 to 8191",
             stall_cycles);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
